FILE: src/shared_array_dual_stack_unit_macros.svh
// ----------------------------------------------------------------------------
// shared_array_dual_stack_unit_macros
// Assertion helpers shared by the dual stack RTL. Clock clk, reset rst.
// ----------------------------------------------------------------------------
`ifndef SHARED_ARRAY_DUAL_STACK_UNIT_MACROS_SVH
`define SHARED_ARRAY_DUAL_STACK_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SADS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dual stack check failed (same cycle)");

// Next-cycle implication, checked outside reset
`define SADS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dual stack check failed (next cycle)");

`endif

FILE: src/sads_pkg.sv
// ----------------------------------------------------------------------------
// sads_pkg
// Shared types and constants for the two-stacks-in-one-array unit.
// ----------------------------------------------------------------------------
package sads_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  // Operation codes on the kind input
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the accepted beat
    logic exec;       // check pointers, write or launch read
    logic read_done;  // read data is ready, present the pop result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pop_go;     // current op is a pop that will succeed
  } stat_t;

endpackage

FILE: src/sads_dp.sv
// ----------------------------------------------------------------------------
// sads_dp
// Datapath: shared word memory, the two stack counts, operand capture and
// the registered result.
// ----------------------------------------------------------------------------
`include "shared_array_dual_stack_unit_macros.svh"

module sads_dp #(
  parameter int DEPTH = sads_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sads_pkg::cmd_t                    cmd,
  output sads_pkg::stat_t                   stat,
  input  logic                              kind,
  input  logic                              stack_sel,
  input  logic signed [sads_pkg::DATA_W-1:0] push_value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [sads_pkg::DATA_W-1:0] pop_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] TOP      = CW'(DEPTH - 1);
  localparam logic [CW:0]   FULL_SUM = (CW + 1)'(DEPTH);

  // Captured operation
  logic                       op_kind;
  logic                       op_sel;
  logic [sads_pkg::DATA_W-1:0] op_value;

  // Stack counts
  logic [CW-1:0] low_count;
  logic [CW-1:0] high_count;

  // Shared memory
  logic [sads_pkg::DATA_W-1:0] mem [DEPTH];
  logic [sads_pkg::DATA_W-1:0] rd_data;

  logic [CW:0]   sum;
  logic          is_full;
  logic [CW-1:0] sel_count;
  logic          push_ok;
  logic          pop_ok;
  logic [CW-1:0] waddr_full;
  logic [CW-1:0] raddr_full;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          mem_we;
  sads_pkg::status_t fail_code;

  // Operand capture on the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind  <= kind;
      op_sel   <= stack_sel;
      op_value <= push_value;
    end
  end

  // Pointer checks and addresses
  always_comb begin
    sum        = {1'b0, low_count} + {1'b0, high_count};
    is_full    = sum >= FULL_SUM;
    sel_count  = op_sel ? high_count : low_count;
    push_ok    = (op_kind == sads_pkg::KIND_PUSH) && !is_full;
    pop_ok     = (op_kind == sads_pkg::KIND_POP) && (sel_count != '0);
    waddr_full = op_sel ? (TOP - high_count) : low_count;
    raddr_full = op_sel ? (TOP - (high_count - CW'(1))) : (low_count - CW'(1));
    waddr      = waddr_full[AW-1:0];
    raddr      = raddr_full[AW-1:0];
    mem_we     = cmd.exec && push_ok;
    if (op_kind == sads_pkg::KIND_POP) begin
      fail_code = sads_pkg::ST_EMPTY;
    end else if (is_full) begin
      fail_code = sads_pkg::ST_FULL;
    end else begin
      fail_code = sads_pkg::ST_OK;
    end
  end

  assign stat.pop_go = pop_ok;

  // Count update
  always_ff @(posedge clk) begin
    if (rst) begin
      low_count  <= '0;
      high_count <= '0;
    end else if (cmd.exec) begin
      if (push_ok) begin
        if (op_sel) high_count <= high_count + CW'(1);
        else        low_count  <= low_count + CW'(1);
      end else if (pop_ok) begin
        if (op_sel) high_count <= high_count - CW'(1);
        else        low_count  <= low_count - CW'(1);
      end
    end
  end

  // Memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= op_value;
    end
    rd_data <= mem[raddr];
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.exec && !pop_ok) || cmd.read_done;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.read_done) begin
      status    <= sads_pkg::ST_OK;
      pop_value <= $signed(rd_data);
    end else if (cmd.exec && !pop_ok) begin
      status    <= fail_code;
      pop_value <= '0;
    end
  end

  `SADS_ASSERT_NOW(a_count_bound, 1'b1, sum <= FULL_SUM)
  `SADS_ASSERT_NEXT(a_done_single, done, !done)
  `SADS_ASSERT_NEXT(a_push_grows, cmd.exec && push_ok,
                    sum == $past(sum) + (CW + 1)'(1))

endmodule

FILE: src/sads_ctrl.sv
// ----------------------------------------------------------------------------
// sads_ctrl
// Controller: sequences accept, execute and, for a successful pop, memory read for each beat.
// ----------------------------------------------------------------------------
`include "shared_array_dual_stack_unit_macros.svh"

module sads_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output sads_pkg::cmd_t  cmd,
  input  sads_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next state
  always_comb begin
    case (state)
      S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = stat.pop_go ? S_READ : S_IDLE;
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  assign busy          = (state != S_IDLE);
  assign cmd.load      = (state == S_IDLE) && start;
  assign cmd.exec      = (state == S_EXEC);
  assign cmd.read_done = (state == S_READ);

  `SADS_ASSERT_NEXT(a_accept_exec, start && !busy, state == S_EXEC)
  `SADS_ASSERT_NEXT(a_pop_reads, cmd.exec && stat.pop_go, state == S_READ)
  `SADS_ASSERT_NEXT(a_read_ends, state == S_READ, state == S_IDLE)

endmodule

FILE: src/shared_array_dual_stack_unit.sv
// ----------------------------------------------------------------------------
// shared_array_dual_stack_unit
// Two stacks sharing one DEPTH-word memory: stack 0 grows up, stack 1 down.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind (0 push, 1 pop), stack_sel and push_value
//   with start high; the beat is taken at the edge where start is high and
//   busy is low. Exactly one result follows each command.
//   Result channel: done is high for one cycle with status (0 ok, 1 full,
//   2 empty) and pop_value (popped word, zero otherwise). The receiver
//   cannot stall; it must take the result in that cycle.
//   Sequence: a push or a refused op passes the execute state, and done
//   rises as it leaves it; a successful pop also passes the read state for
//   the registered memory read. busy drops as done rises, so a new command
//   can be taken once the result shows, and none is taken while an op is
//   in flight. The registered memory read and the execute step set the pace.
//   Reset (rst, synchronous) empties both stacks and drops busy and done.
//   Memory contents are not cleared; only written words are ever read.
// ----------------------------------------------------------------------------
module shared_array_dual_stack_unit #(
  parameter int DEPTH = sads_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic                               stack_sel,
  input  logic signed [sads_pkg::DATA_W-1:0] push_value,
  output logic                               done,
  output logic [1:0]                         status,
  output logic signed [sads_pkg::DATA_W-1:0] pop_value
);

  sads_pkg::cmd_t  cmd;
  sads_pkg::stat_t stat;

  // Sequencer
  sads_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Memory, counts and result
  sads_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .stack_sel  (stack_sel),
    .push_value (push_value),
    .done       (done),
    .status     (status),
    .pop_value  (pop_value)
  );

endmodule
